// ===== src/cbet_pkg.sv =====
// Package for the cubic Bezier easing table block: types, constants and fixed-point helpers.
// Used by cbet_ctrl, cbet_dp and cubic_bezier_easing_table. No dependencies.
package cbet_pkg;

   localparam int TableSizeDefault = 64;
   localparam int MaxIterDefault   = 16;
   localparam int WideW   = 24;
   localparam int FracW   = 16;
   localparam int TolLsb  = 7;

   typedef logic signed [WideW-1:0] wide_type;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_LOAD  = 4'd1,
      OP_MUL   = 4'd2,
      OP_ADD   = 4'd3,
      OP_DIV   = 4'd4,
      OP_STEP  = 4'd5
   } op_type;

   // Multiplier/adder operand selects.
   typedef enum logic [2:0] {
      SEL_ACC = 3'd0,
      SEL_A   = 3'd1,
      SEL_B   = 3'd2,
      SEL_C   = 3'd3,
      SEL_S   = 3'd4,
      SEL_NT  = 3'd5
   } sel_type;

   typedef struct packed {
      op_type  op;
      sel_type sel_l;
      sel_type sel_r;
      logic    coef_y;
      logic    coef_d;
      logic    save_err;
   } cmd_type;

   typedef struct packed {
      logic err_ok;
      logic d_zero;
      logic div_busy;
   } sts_type;

   function automatic wide_type sat_wide(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      begin
         hi = 64'sd8388607;
         lo = -64'sd8388608;
         if (v > hi) begin
            sat_wide = wide_type'(hi);
         end else if (v < lo) begin
            sat_wide = wide_type'(lo);
         end else begin
            sat_wide = wide_type'(v);
         end
      end
   endfunction

   // Since 65536 = 516 * 127 + 4, the rounded quotient is 516v plus floor((4v + 63) / 127),
   // and that small remainder term is found by comparing against multiples of 127.
   function automatic wide_type ctrl_q16(input logic [6:0] v);
      logic [9:0] r;
      logic [2:0] f;
      begin
         r = {1'b0, v, 2'b00} + 10'd63;
         f = 3'(r >= 10'd127) + 3'(r >= 10'd254) + 3'(r >= 10'd381) + 3'(r >= 10'd508);
         ctrl_q16 = wide_type'({17'd0, v} * 24'd516 + {21'd0, f});
      end
   endfunction

endpackage

// ===== src/cbet_ctrl.sv =====
// Controller state machine for the easing table block.
// Sequences Horner evaluations and Newton divides on cbet_dp; depends on cbet_pkg.
module cbet_ctrl #(
   parameter int MAX_ITERATIONS = cbet_pkg::MaxIterDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              bypass,
   input  logic              out_free,
   input  cbet_pkg::sts_type sts,
   output cbet_pkg::cmd_type cmd,
   output logic              busy,
   output logic              done,
   output logic              limit
);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOAD = 9'b000000010,
      ST_EVX  = 9'b000000100,
      ST_CHK  = 9'b000001000,
      ST_EVD  = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_STEP = 9'b001000000,
      ST_EVY  = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

   localparam int IterW = $clog2(MAX_ITERATIONS + 1);

   state_type        state_ff, state_in;
   logic [2:0]       ph_ff, ph_in;
   logic [IterW-1:0] iter_ff, iter_in;
   logic             limit_ff, limit_in;

   // Horner micro-steps: mul(a,s) add(b) mul(s) add(c) [mul(s)] [add(-t), saving the error].
   function automatic cbet_pkg::cmd_type horner(input logic [2:0] ph, input logic y,
                                                input logic d);
      cbet_pkg::cmd_type c;
      begin
         c = '0;
         c.coef_y = y;
         c.coef_d = d;
         case (ph)
            3'd0: begin
               c.op = cbet_pkg::OP_MUL; c.sel_l = cbet_pkg::SEL_A; c.sel_r = cbet_pkg::SEL_S;
            end
            3'd1: begin
               c.op = cbet_pkg::OP_ADD; c.sel_l = cbet_pkg::SEL_ACC; c.sel_r = cbet_pkg::SEL_B;
            end
            3'd2: begin
               c.op = cbet_pkg::OP_MUL; c.sel_l = cbet_pkg::SEL_ACC; c.sel_r = cbet_pkg::SEL_S;
            end
            3'd3: begin
               c.op = cbet_pkg::OP_ADD; c.sel_l = cbet_pkg::SEL_ACC; c.sel_r = cbet_pkg::SEL_C;
            end
            3'd4: begin
               c.op = cbet_pkg::OP_MUL; c.sel_l = cbet_pkg::SEL_ACC; c.sel_r = cbet_pkg::SEL_S;
            end
            3'd5: begin
               c.op = cbet_pkg::OP_ADD; c.sel_l = cbet_pkg::SEL_ACC; c.sel_r = cbet_pkg::SEL_NT;
               c.save_err = 1'b1;
            end
            default: c.op = cbet_pkg::OP_NONE;
         endcase
         horner = c;
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      ph_in    = ph_ff;
      iter_in  = iter_ff;
      limit_in = limit_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               limit_in = 1'b0;
               state_in = bypass ? ST_DONE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op   = cbet_pkg::OP_LOAD;
            iter_in  = '0;
            ph_in    = '0;
            state_in = ST_EVX;
         end
         ST_EVX: begin
            cmd   = horner(ph_ff, 1'b0, 1'b0);
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd5) begin
               ph_in    = '0;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (sts.err_ok) begin
               state_in = ST_EVY;
            end else if (iter_ff == IterW'(MAX_ITERATIONS)) begin
               limit_in = 1'b1;
               state_in = ST_EVY;
            end else begin
               state_in = ST_EVD;
            end
         end
         ST_EVD: begin
            cmd   = horner(ph_ff, 1'b0, 1'b1);
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd3) begin
               ph_in    = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (sts.d_zero) begin
               state_in = ST_EVY;
            end else begin
               cmd.op   = cbet_pkg::OP_DIV;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (!sts.div_busy) begin
               cmd.op   = cbet_pkg::OP_STEP;
               iter_in  = iter_ff + IterW'(1);
               state_in = ST_EVX;
            end
         end
         ST_EVY: begin
            cmd   = horner(ph_ff, 1'b1, 1'b0);
            ph_in = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               ph_in    = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // The entry waits here until the output register can take it.
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ph_ff    <= '0;
         iter_ff  <= '0;
         limit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ph_ff    <= ph_in;
         iter_ff  <= iter_in;
         limit_ff <= limit_in;
      end
   end

   assign busy  = (state_ff != ST_IDLE);
   assign done  = (state_ff == ST_DONE) && out_free;
   assign limit = limit_ff;

`ifndef SYNTHESIS
   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= IterW'(MAX_ITERATIONS)) else $error("iteration count overran");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held two cycles");
   a_step_after_div: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cbet_pkg::OP_STEP) |-> !sts.div_busy) else $error("step while dividing");
`endif

endmodule

// ===== src/cbet_dp.sv =====
// Datapath for the easing table block: coefficient registers, one shared multiplier and adder,
// and a radix-2 restoring divider for the Newton step. Depends on cbet_pkg.
module cbet_dp #(
   parameter int TABLE_SIZE = cbet_pkg::TableSizeDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               capture,
   input  logic [6:0]         ctrl_x1,
   input  logic [6:0]         ctrl_y1,
   input  logic [6:0]         ctrl_x2,
   input  logic [6:0]         ctrl_y2,
   input  logic [6:0]         sample_index,
   input  cbet_pkg::cmd_type  cmd,
   output cbet_pkg::sts_type  sts,
   output logic [15:0]        eased_value,
   output logic               is_linear
);

   localparam int QW = 40;           // quotient width: (|err| << 16) fits 40 bits
   localparam int CntW = $clog2(QW + 1);
   // Reciprocal of the table size scaled by 2^33; exact for every 7-bit index.
   localparam logic [33:0] RecipT =
      34'(((64'd1 << 33) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

   cbet_pkg::wide_type ax_ff, bx_ff, cx_ff, ay_ff, by_ff, cy_ff;
   cbet_pkg::wide_type acc_ff, acc_in, err_ff, s_ff, t_ff;
   logic [6:0]         x1_ff, y1_ff, x2_ff, y2_ff, k_ff;
   logic [QW-1:0]      num_ff, quo_ff;
   logic [QW:0]        rem_ff;
   logic [23:0]        den_ff;
   logic               qneg_ff;
   logic [CntW-1:0]    cnt_ff;
   logic               dbusy_ff;

   cbet_pkg::wide_type a_sel, b_sel, c_sel, opl, opr;
   logic signed [47:0] prod;
   logic [47:0]        pmag;
   logic [47:0]        rmag;
   logic signed [63:0] rsum;
   logic [QW:0]        rtry;
   logic [40:0]        k_scaled;
   cbet_pkg::wide_type t_val;
   logic signed [63:0] q_signed;
   logic signed [63:0] s_next;

   always_comb begin
      if (cmd.coef_y) begin
         a_sel = ay_ff; b_sel = by_ff; c_sel = cy_ff;
      end else if (cmd.coef_d) begin
         a_sel = cbet_pkg::sat_wide(64'(ax_ff) * 64'sd3);
         b_sel = cbet_pkg::sat_wide(64'(bx_ff) * 64'sd2);
         c_sel = cx_ff;
      end else begin
         a_sel = ax_ff; b_sel = bx_ff; c_sel = cx_ff;
      end
   end

   function automatic cbet_pkg::wide_type pick(input cbet_pkg::sel_type sel,
      input cbet_pkg::wide_type acc, input cbet_pkg::wide_type a, input cbet_pkg::wide_type b,
      input cbet_pkg::wide_type c, input cbet_pkg::wide_type s, input cbet_pkg::wide_type t);
      begin
         case (sel)
            cbet_pkg::SEL_ACC: pick = acc;
            cbet_pkg::SEL_A:   pick = a;
            cbet_pkg::SEL_B:   pick = b;
            cbet_pkg::SEL_C:   pick = c;
            cbet_pkg::SEL_S:   pick = s;
            cbet_pkg::SEL_NT:  pick = -t;
            default:           pick = acc;
         endcase
      end
   endfunction

   always_comb begin
      opl  = pick(cmd.sel_l, acc_ff, a_sel, b_sel, c_sel, s_ff, t_ff);
      opr  = pick(cmd.sel_r, acc_ff, a_sel, b_sel, c_sel, s_ff, t_ff);
      prod = 48'(opl) * 48'(opr);
      pmag = prod[47] ? 48'(-prod) : 48'(prod);
      rmag = (pmag + 48'd32768) >> 16;
      if (prod[47]) begin
         rsum = -64'(signed'({16'd0, rmag}));
      end else begin
         rsum = 64'(signed'({16'd0, rmag}));
      end
      case (cmd.op)
         cbet_pkg::OP_MUL: acc_in = cbet_pkg::sat_wide(rsum);
         cbet_pkg::OP_ADD: acc_in = cbet_pkg::sat_wide(64'(opl) + 64'(opr));
         default:          acc_in = acc_ff;
      endcase
      rtry = {rem_ff[QW-1:0], num_ff[QW-1]} - {{(QW-23){1'b0}}, den_ff};
   end

   // Newton update s - q, saturated to the narrow range.
   always_comb begin
      q_signed = qneg_ff ? -signed'(64'(quo_ff)) : signed'(64'(quo_ff));
      s_next   = 64'(s_ff) - q_signed;
   end

   // t = floor(k * 2^16 / TABLE_SIZE) by reciprocal multiplication.
   assign k_scaled = {34'd0, k_ff} * {7'd0, RecipT};
   assign t_val    = cbet_pkg::wide_type'(k_scaled[40:17]);

   assign sts.err_ok   = (err_ff <= cbet_pkg::wide_type'(cbet_pkg::TolLsb))
                      && (err_ff >= -cbet_pkg::wide_type'(cbet_pkg::TolLsb));
   assign sts.d_zero   = (acc_ff == '0);
   assign sts.div_busy = dbusy_ff;

   // Coefficients a = 1 + 3p1 - 3p2, b = 3p2 - 6p1, c = 3p1.
   function automatic cbet_pkg::wide_type coef_a(input logic [6:0] p1, input logic [6:0] p2);
      coef_a = cbet_pkg::sat_wide(64'sd65536 + 64'(cbet_pkg::ctrl_q16(p1)) * 64'sd3
                                  - 64'(cbet_pkg::ctrl_q16(p2)) * 64'sd3);
   endfunction
   function automatic cbet_pkg::wide_type coef_b(input logic [6:0] p1, input logic [6:0] p2);
      coef_b = cbet_pkg::sat_wide(64'(cbet_pkg::ctrl_q16(p2)) * 64'sd3
                                  - 64'(cbet_pkg::ctrl_q16(p1)) * 64'sd6);
   endfunction

   always_ff @(posedge clock) begin
      if (capture) begin
         x1_ff <= ctrl_x1; y1_ff <= ctrl_y1; x2_ff <= ctrl_x2; y2_ff <= ctrl_y2;
         k_ff  <= sample_index;
      end
      if (cmd.op == cbet_pkg::OP_LOAD) begin
         ax_ff <= coef_a(x1_ff, x2_ff);
         bx_ff <= coef_b(x1_ff, x2_ff);
         cx_ff <= cbet_pkg::sat_wide(64'(cbet_pkg::ctrl_q16(x1_ff)) * 64'sd3);
         ay_ff <= coef_a(y1_ff, y2_ff);
         by_ff <= coef_b(y1_ff, y2_ff);
         cy_ff <= cbet_pkg::sat_wide(64'(cbet_pkg::ctrl_q16(y1_ff)) * 64'sd3);
         t_ff  <= t_val;
         s_ff  <= t_val;
      end
      acc_ff <= acc_in;
      if (cmd.save_err) begin
         err_ff <= acc_in;
      end
      if (cmd.op == cbet_pkg::OP_STEP) begin
         if (s_next > 64'sd524287) begin
            s_ff <= 24'sd524287;
         end else if (s_next < -64'sd524288) begin
            s_ff <= -24'sd524288;
         end else begin
            s_ff <= 24'(s_next);
         end
      end
   end

   // Bit-serial divider: one quotient bit a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (cmd.op == cbet_pkg::OP_DIV) begin
         dbusy_ff <= 1'b1;
         cnt_ff   <= CntW'(QW);
         num_ff   <= {err_ff[23] ? QW'(-64'(err_ff)) : QW'(64'(err_ff))} << 16;
         den_ff   <= acc_ff[23] ? 24'(-acc_ff) : 24'(acc_ff);
         qneg_ff  <= err_ff[23] != acc_ff[23];
         rem_ff   <= '0;
         quo_ff   <= '0;
      end else if (dbusy_ff) begin
         num_ff <= num_ff << 1;
         if (!rtry[QW]) begin
            rem_ff <= rtry;
            quo_ff <= {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[QW-1:0], num_ff[QW-1]};
            quo_ff <= {quo_ff[QW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            dbusy_ff <= 1'b0;
         end
      end
   end

   logic [15:0] lin_val;
   logic [15:0] y_out;
   // floor(k * 2^15 / TABLE_SIZE); only used below the final index.
   assign lin_val = k_scaled[33:18];
   always_comb begin
      if (acc_ff[23]) begin
         y_out = 16'd0;
      end else if (((25'(acc_ff) + 25'd1) >> 1) > 25'd32768) begin
         y_out = 16'd32768;
      end else begin
         y_out = 16'(((25'(acc_ff) + 25'd1) >> 1));
      end
   end

   // The result is valid while the controller sits in its done state.
   logic lin_now;
   assign lin_now = (x1_ff == y1_ff) && (x2_ff == y2_ff);
   always_comb begin
      if (32'(k_ff) >= TABLE_SIZE) begin
         eased_value = 16'd32768;
      end else if (lin_now) begin
         eased_value = lin_val;
      end else begin
         eased_value = y_out;
      end
   end

   assign is_linear = lin_now;

`ifndef SYNTHESIS
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == cbet_pkg::OP_DIV) |-> (acc_ff != '0)) else $error("divide by zero");
   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (dbusy_ff && cnt_ff > CntW'(1)) |=> dbusy_ff) else $error("divider quit early");
   a_s_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.op == cbet_pkg::OP_STEP) |-> (s_ff <= 24'sd524287 && s_ff >= -24'sd524288))
      else $error("s out of range");
`endif

endmodule

// ===== src/cubic_bezier_easing_table.sv =====
// Cubic Bezier easing table entry. An index at or beyond TABLE_SIZE or a linear curve skips
// the Newton search; otherwise at most MAX_ITERATIONS Newton steps run on the shared
// multiplier and the bit-serial divider, ending once the error is within tolerance or the slope is zero.
// One request is computed at a time; the next may be taken while a result waits, and the
// block holds in its done state until the output register is free. Synchronous active-high
// reset clears the controller and the output valid; no clearing pass.
module cubic_bezier_easing_table #(
   parameter int TABLE_SIZE     = cbet_pkg::TableSizeDefault,
   parameter int MAX_ITERATIONS = cbet_pkg::MaxIterDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, sample_index, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // eased_value
   output logic [1:0]  rsp_tuser   // is_linear, hit_iteration_limit
);

   cbet_pkg::cmd_type cmd;
   cbet_pkg::sts_type sts;
   logic              busy, done, limit, start, bypass, rvalid_ff, out_free;
   logic [15:0]       eased;
   logic              linear;

   assign req_tready = !busy;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rvalid_ff || rsp_tready;
   // Bypass when the index is at or beyond the table size or the curve is linear.
   assign bypass     = (32'(req_tdata[34:28]) >= TABLE_SIZE)
                    || ((req_tdata[6:0] == req_tdata[13:7]) && (req_tdata[20:14] == req_tdata[27:21]));

   cbet_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
      .clock, .reset, .start, .bypass, .out_free, .sts, .cmd, .busy, .done, .limit
   );

   cbet_dp #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
      .clock, .reset, .capture(start),
      .ctrl_x1(req_tdata[6:0]), .ctrl_y1(req_tdata[13:7]),
      .ctrl_x2(req_tdata[20:14]), .ctrl_y2(req_tdata[27:21]),
      .sample_index(req_tdata[34:28]),
      .cmd, .sts, .eased_value(eased), .is_linear(linear)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (done) begin
         rvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_tdata <= eased;
         rsp_tuser <= {limit, linear};
      end
   end

   assign rsp_tvalid = rvalid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> (!rvalid_ff || rsp_tready)) else $error("waiting result overwritten");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("result lost");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid) else $error("result dropped");
`endif

endmodule

// ===== verif/cbet_checker.sv =====
// Checker for the cubic Bezier easing table: watches both stream channels, predicts each entry
// and compares it with the returned one. Depends on the cubic_bezier_easing_table port layout.
module cbet_checker #(
   parameter int TABLE_SIZE     = 64,
   parameter int MAX_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   output int          mismatches,
   output int          outstanding,
   output int          entries_seen,
   output int          limit_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint WideLim   = longint'(1) << 23;
   localparam longint NarrowLim = longint'(1) << 19;
   localparam longint Tolerance = 7;

   typedef struct packed {
      logic [15:0] eased_value;
      logic        is_linear;
      logic        hit_iteration_limit;
   } entry_type;

   entry_type expected_entries[$];

   function automatic longint clip(input longint v, input longint lim);
      if (v > lim - 1) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // Product rounded to nearest with ties away from zero.
   function automatic longint fmul(input longint a, input longint b);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + 32768) >>> 16;
      return clip((p < 0) ? -m : m, WideLim);
   endfunction

   function automatic longint fadd(input longint a, input longint b);
      return clip(a + b, WideLim);
   endfunction

   function automatic longint to_fixed(input logic [6:0] v);
      return (longint'(v) * 65536 + 63) / 127;
   endfunction

   function automatic longint bezier_at(input longint a, input longint b, input longint c,
                                        input longint s);
      longint h;
      h = fadd(fmul(a, s), b);
      h = fadd(fmul(h, s), c);
      return fmul(h, s);
   endfunction

   function automatic longint bezier_slope(input longint a, input longint b, input longint c,
                                           input longint s);
      longint h;
      h = fadd(fmul(clip(3 * a, WideLim), s), clip(2 * b, WideLim));
      return fadd(fmul(h, s), c);
   endfunction

   function automatic entry_type ease_entry(input logic [39:0] word);
      logic [6:0] x1, y1, x2, y2, k;
      longint px1, px2, py1, py2, ax, bx, cx, ay, by, cy, t, s, y, err, d, q, mn, md;
      int step;
      entry_type e;
      x1 = word[6:0];
      y1 = word[13:7];
      x2 = word[20:14];
      y2 = word[27:21];
      k  = word[34:28];
      e.is_linear = (x1 == y1) && (x2 == y2);
      e.hit_iteration_limit = 1'b0;
      if (k >= TABLE_SIZE) begin
         e.eased_value = 16'd32768;
      end else if (e.is_linear) begin
         e.eased_value = 16'((longint'(k) << 15) / TABLE_SIZE);
      end else begin
         px1 = to_fixed(x1);
         px2 = to_fixed(x2);
         py1 = to_fixed(y1);
         py2 = to_fixed(y2);
         ax = clip(65536 + 3 * px1 - 3 * px2, WideLim);
         bx = clip(3 * px2 - 6 * px1, WideLim);
         cx = clip(3 * px1, WideLim);
         ay = clip(65536 + 3 * py1 - 3 * py2, WideLim);
         by = clip(3 * py2 - 6 * py1, WideLim);
         cy = clip(3 * py1, WideLim);
         t = (longint'(k) << 16) / TABLE_SIZE;
         s = t;
         step = 0;
         forever begin
            err = fadd(bezier_at(ax, bx, cx, s), -t);
            if (err <= Tolerance && err >= -Tolerance) break;
            if (step >= MAX_ITERATIONS) begin
               e.hit_iteration_limit = 1'b1;
               break;
            end
            d = bezier_slope(ax, bx, cx, s);
            if (d == 0) break;
            mn = (err < 0) ? -err : err;
            md = (d < 0) ? -d : d;
            q  = (mn << 16) / md;
            if ((err < 0) != (d < 0)) q = -q;
            s = clip(s - q, NarrowLim);
            step++;
         end
         y = bezier_at(ay, by, cy, s);
         if (y < 0) begin
            e.eased_value = 16'd0;
         end else begin
            y = (y + 1) >>> 1;
            e.eased_value = (y > 32768) ? 16'd32768 : 16'(y);
         end
      end
      return e;
   endfunction

   initial begin
      mismatches   = 0;
      entries_seen = 0;
      limit_hits   = 0;
   end

   assign outstanding = expected_entries.size();

   always @(posedge clock) begin
      entry_type want;
      entry_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_entries.push_back(ease_entry(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.eased_value         = rsp_tdata;
            got.is_linear           = rsp_tuser[0];
            got.hit_iteration_limit = rsp_tuser[1];
            entries_seen++;
            if (got.hit_iteration_limit) limit_hits++;
            if (expected_entries.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected result: value %0d linear %0b limit %0b", $realtime,
                           got.eased_value, got.is_linear, got.hit_iteration_limit);
            end else begin
               want = expected_entries.pop_front();
               if (want != got) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("[%0t] mismatch: value %0d/%0d linear %0b/%0b limit %0b/%0b",
                              $realtime, want.eased_value, got.eased_value, want.is_linear,
                              got.is_linear, want.hit_iteration_limit,
                              got.hit_iteration_limit);
               end
            end
         end
      end
   end

endmodule

// ===== verif/tb_cubic_bezier_easing_table.sv =====
// Testbench top for cubic_bezier_easing_table: clock, reset, request and response stimulus
// and the verdict. Depends on cbet_pkg, the block and cbet_checker.
module tb_cubic_bezier_easing_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TableSize = cbet_pkg::TableSizeDefault;
   localparam int MaxIter   = cbet_pkg::MaxIterDefault;
   localparam int RandomRequests = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   int mismatches, outstanding, entries_seen, limit_hits;
   bit idling_on = 1'b1;
   bit hold_request = 1'b0;
   int hold_left = 0;

   always #10 clock = ~clock;

   cubic_bezier_easing_table #(.TABLE_SIZE(TableSize), .MAX_ITERATIONS(MaxIter)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   cbet_checker #(.TABLE_SIZE(TableSize), .MAX_ITERATIONS(MaxIter)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatches(mismatches), .outstanding(outstanding),
      .entries_seen(entries_seen), .limit_hits(limit_hits)
   );

   task automatic send_entry(input logic [6:0] x1, input logic [6:0] y1, input logic [6:0] x2,
                             input logic [6:0] y2, input logic [6:0] k);
      while (idling_on && $urandom_range(99) < 8) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {5'd0, k, y2, x2, y1, x1};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [6:0] pick_ctrl();
      case ($urandom_range(5))
         0: return 7'd0;
         1: return 7'd127;
         default: return 7'($urandom_range(127));
      endcase
   endfunction

   // Response side: random stalls, plus one long hold-off when requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready = 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left = 3000;
         rsp_tready = 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = !(idling_on && $urandom_range(99) < 8);
      end
   end

   initial begin
      logic [6:0] x1, y1, x2, y2, k;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: extremes, linear curves, final index, beyond the table, flat slopes.
      send_entry(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      send_entry(7'd0, 7'd0, 7'd127, 7'd127, 7'd17);
      send_entry(7'd50, 7'd50, 7'd90, 7'd90, 7'd64);
      send_entry(7'd127, 7'd127, 7'd127, 7'd127, 7'd63);
      send_entry(7'd127, 7'd0, 7'd0, 7'd127, 7'd0);
      send_entry(7'd127, 7'd0, 7'd0, 7'd127, 7'd1);
      send_entry(7'd127, 7'd0, 7'd0, 7'd127, 7'd32);
      send_entry(7'd127, 7'd0, 7'd0, 7'd127, 7'd63);
      send_entry(7'd127, 7'd0, 7'd0, 7'd127, 7'd64);
      send_entry(7'd127, 7'd0, 7'd0, 7'd127, 7'd127);
      send_entry(7'd0, 7'd127, 7'd127, 7'd0, 7'd1);
      send_entry(7'd0, 7'd127, 7'd127, 7'd0, 7'd32);
      send_entry(7'd0, 7'd127, 7'd127, 7'd0, 7'd62);
      send_entry(7'd127, 7'd127, 7'd0, 7'd0, 7'd40);
      send_entry(7'd0, 7'd127, 7'd0, 7'd127, 7'd5);
      send_entry(7'd127, 7'd0, 7'd127, 7'd0, 7'd59);
      send_entry(7'd42, 7'd21, 7'd85, 7'd106, 7'd96);
      send_entry(7'd85, 7'd42, 7'd21, 7'd106, 7'd31);
      send_entry(7'd64, 7'd0, 7'd64, 7'd127, 7'd48);
      send_entry(7'd1, 7'd126, 7'd126, 7'd1, 7'd2);

      for (int n = 0; n < RandomRequests; n++) begin
         idling_on = !(n >= 300 && n < 600);
         if (n == 700) hold_request = 1'b1;
         x1 = pick_ctrl();
         y1 = pick_ctrl();
         x2 = pick_ctrl();
         y2 = pick_ctrl();
         if ($urandom_range(9) == 0) begin
            y1 = x1;
            y2 = x2;
         end
         k = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
         send_entry(x1, y1, x2, y2, k);
      end
      req_tvalid = 1'b0;
      idling_on = 1'b1;

      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Checked %0d table entries with random control points and indices,", entries_seen);
      $display("including %0d that hit the iteration bound, under stalls on both channels.",
               limit_hits);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Timed out with %0d results still awaited.", outstanding);
      $display("== FAIL ==");
      $finish;
   end

endmodule
